// File: sv/pdc_pkg.sv
// Shared types, constants and the CRC-16/X-25 byte step for the packet deframer.
// No dependencies; the parser, the result register and the top level import this package.
`default_nettype none

package pdc_pkg;

   localparam logic [15:0] CrcAll1   = 16'hFFFF;
   localparam logic [3:0]  HdrBytes  = 4'd9;

   localparam logic [3:0]  HdrIdxType   = 4'd0;
   localparam logic [3:0]  HdrIdxCrcHi  = 4'd1;
   localparam logic [3:0]  HdrIdxCrcLo  = 4'd2;
   localparam logic [3:0]  HdrIdxStamp0 = 4'd3;
   localparam logic [3:0]  HdrIdxStamp1 = 4'd4;
   localparam logic [3:0]  HdrIdxStamp2 = 4'd5;
   localparam logic [3:0]  HdrIdxStamp3 = 4'd6;

   localparam int RspDataBits = 72;

   typedef struct packed {
      logic        crc_good;
      logic [15:0] payload_length;
      logic [31:0] time_stamp;
      logic [7:0]  packet_type;
      logic        empty_packet;
      logic        is_last;
      logic [7:0]  payload_byte;
   } pdc_result_type;

   function automatic logic [15:0] crc_x25_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] t;
      t = crc[7:0] ^ b;
      t = t ^ {t[3:0], 4'h0};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

endpackage

`default_nettype wire

// File: sv/pdc_parser.sv
// Header parser, payload pass-through and running CRC for the packet deframer.
// Depends on pdc_pkg for the result type, header indexes and the CRC byte step.
`default_nettype none

module pdc_parser (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    fire,
   input  wire  [7:0]             rx_byte,
   input  wire                    packet_start,
   output logic                   res_valid,
   output pdc_pkg::pdc_result_type res
);
   import pdc_pkg::*;

   typedef enum logic [1:0] {
      PhIdle    = 2'd0,
      PhHeader  = 2'd1,
      PhPayload = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in, phase_eff;
   logic [3:0]  count_ff, count_in, count_eff;
   logic [7:0]  type_ff, type_in;
   logic [15:0] scrc_ff, scrc_in, scrc_eff;
   logic [31:0] stamp_ff, stamp_in, stamp_eff;
   logic [15:0] len_ff, len_in, len_eff;
   logic [15:0] rem_ff, rem_in, rem_eff;
   logic [15:0] rcrc_ff, rcrc_in, rcrc_eff;

   always_comb begin
      phase_eff = packet_start ? PhHeader : phase_ff;
      count_eff = packet_start ? 4'd0 : count_ff;
      scrc_eff  = packet_start ? 16'h0000 : scrc_ff;
      stamp_eff = packet_start ? 32'h0 : stamp_ff;
      len_eff   = packet_start ? 16'h0000 : len_ff;
      rem_eff   = packet_start ? 16'h0000 : rem_ff;
      rcrc_eff  = packet_start ? CrcAll1 : rcrc_ff;

      phase_in  = phase_eff;
      count_in  = count_eff;
      type_in   = type_ff;
      scrc_in   = scrc_eff;
      stamp_in  = stamp_eff;
      len_in    = len_eff;
      rem_in    = rem_eff;
      rcrc_in   = rcrc_eff;
      res_valid = 1'b0;

      case (phase_eff)
         PhHeader: begin
            case (count_eff)
               HdrIdxType: type_in = rx_byte;
               HdrIdxCrcHi, HdrIdxCrcLo: scrc_in = {scrc_eff[7:0], rx_byte};
               HdrIdxStamp0, HdrIdxStamp1, HdrIdxStamp2, HdrIdxStamp3: begin
                  stamp_in = {stamp_eff[23:0], rx_byte};
               end
               default: len_in = {len_eff[7:0], rx_byte};
            endcase
            count_in = count_eff + 4'd1;
            if (count_in >= HdrBytes) begin
               if (len_in == 16'h0000) begin
                  phase_in  = PhIdle;
                  res_valid = 1'b1;
               end else begin
                  rem_in   = len_in;
                  phase_in = PhPayload;
               end
            end
         end
         PhPayload: begin
            rcrc_in   = crc_x25_byte(rcrc_eff, rx_byte);
            rem_in    = rem_eff - 16'd1;
            res_valid = 1'b1;
            if (rem_in == 16'h0000) begin
               phase_in = PhIdle;
            end
         end
         default: begin
            phase_in = PhIdle;
         end
      endcase

      res.payload_byte   = (phase_eff == PhPayload) ? rx_byte : 8'h00;
      res.is_last        = (phase_eff == PhPayload) ? (rem_in == 16'h0000) : 1'b1;
      res.empty_packet   = (phase_eff != PhPayload);
      res.packet_type    = type_in;
      res.time_stamp     = stamp_in;
      res.payload_length = len_in;
      res.crc_good       = res.is_last && ((rcrc_in ^ CrcAll1) == scrc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhIdle;
         count_ff <= 4'd0;
         type_ff  <= 8'h00;
         scrc_ff  <= 16'h0000;
         stamp_ff <= 32'h0;
         len_ff   <= 16'h0000;
         rem_ff   <= 16'h0000;
         rcrc_ff  <= CrcAll1;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         type_ff  <= type_in;
         scrc_ff  <= scrc_in;
         stamp_ff <= stamp_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
         rcrc_ff  <= rcrc_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/pdc_out_reg.sv
// Result register of the packet deframer, driving the rsp_ stream channel.
// Depends on pdc_pkg for the result type and the packed data width.
`default_nettype none

module pdc_out_reg (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          fire,
   input  wire                          res_valid,
   input  pdc_pkg::pdc_result_type      res,
   output logic                         advance,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [pdc_pkg::RspDataBits-1:0] rsp_tdata,
   output logic                         rsp_tlast,
   output logic                         rsp_tuser
);
   import pdc_pkg::*;

   logic           valid_ff, valid_in;
   pdc_result_type res_ff;

   assign advance  = !valid_ff || rsp_tready;
   assign valid_in = fire && res_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance && valid_in) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'b0000000, res_ff.crc_good, res_ff.payload_length,
                        res_ff.time_stamp, res_ff.packet_type, res_ff.payload_byte};
   assign rsp_tlast  = res_ff.is_last;
   assign rsp_tuser  = res_ff.empty_packet;

endmodule

`default_nettype wire

// File: sv/packet_deframer_crc16_check.sv
// Top level of the CRC-16/X-25 checked packet deframer.
// Depends on pdc_pkg, pdc_parser and pdc_out_reg.
//
// The req_ channel carries one datagram byte per word; req_tuser marks the
// first byte of a datagram and restarts the parser, dropping any partial one.
// The nine header bytes (type, stored CRC, timestamp, length, big-endian)
// give no result. Each payload byte then comes out as one word on the rsp_
// channel together with the header fields; rsp_tlast marks the last byte of
// the packet, and on that word tdata bit 64 tells whether the CRC matched.
// A header with zero length gives a single word with rsp_tuser and rsp_tlast
// set and a zero payload byte. Bytes outside a datagram are dropped.
// An accepted word is held in the input register and is parsed into the
// result register when that register can advance, so each result passes
// through both registers. One word is accepted per cycle while rsp_tready is
// high, a rate set by the combinational CRC byte update between the registers.
// When rsp_tready is low the result holds and both registers fill, after
// which req_tready drops. Reset clears the parser and empties both stages.
`default_nettype none

module packet_deframer_crc16_check (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire         req_tuser,   // [0] packet_start
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // [7:0] payload_byte, [15:8] packet_type,
                                    // [47:16] time_stamp, [63:48] payload_length,
                                    // [64] crc_good, [71:65] zero
   output logic        rsp_tlast,   // is_last
   output logic        rsp_tuser    // [0] empty_packet
);
   import pdc_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_start_ff;
   logic           advance;
   logic           fire;
   logic           res_valid;
   pdc_result_type res;

   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   pdc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .rx_byte      (in_byte_ff),
      .packet_start (in_start_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   pdc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .res_valid  (res_valid),
      .res        (res),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: sv/pdc_checker.sv
// Port-level checker for the packet deframer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module pdc_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [71:0] rsp_tdata,
   input wire        rsp_tlast,
   input wire        rsp_tuser
);

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("empty packet word without last flag");

   a_empty_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[7:0] == 8'h00)
      else $error("empty packet word carries a byte");

   a_good_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_tdata[64])
      else $error("crc_good set on a word that is not last");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind packet_deframer_crc16_check pdc_checker u_pdc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
